FILE: rtl/fircv_pkg.sv
`default_nettype none

package fircv_pkg;

  // tap format: signed q2.14
  localparam int TAP_BITS      = 16;
  localparam int TAPS_PER_WORD = 4;

  // result width, units of 2^-14
  localparam int FILT_W = 35;

  // configuration port
  localparam int KSIZE_W    = 4;
  localparam int CFG_DATA_W = 64;
  localparam int CFG_ADDR_W = 5;
  localparam int REG_IDX_W  = 2;

  localparam logic [REG_IDX_W-1:0] REG_KSIZE   = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_TAPS_LO = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_TAPS_HI = 2'd2;

  localparam logic [KSIZE_W-1:0]    KSIZE_RST   = 4'd1;
  localparam logic [CFG_DATA_W-1:0] TAPS_LO_RST = 64'd16384;
  localparam logic [CFG_DATA_W-1:0] TAPS_HI_RST = 64'd0;

  // control that travels with a sum through the adder tree
  typedef struct packed {
    logic valid;
    logic eol;
  } fircv_tag_t;

endpackage

`default_nettype wire

FILE: rtl/fircv_cell.sv
`default_nettype none

module fircv_cell #(
  parameter int SAMPLE_BITS = 16
) (
  input  wire  logic                                                clk_i,
  input  wire  logic                                                rst_ni,
  input  wire  logic                                                shift_i,
  input  wire  logic signed [SAMPLE_BITS-1:0]                       sample_i,
  input  wire  logic signed [fircv_pkg::TAP_BITS-1:0]               tap_i,
  output logic signed [SAMPLE_BITS-1:0]                             sample_o,
  output logic signed [SAMPLE_BITS+fircv_pkg::TAP_BITS-1:0]         prod_o
);
  import fircv_pkg::*;

  localparam int PW = SAMPLE_BITS + TAP_BITS;

  logic signed [SAMPLE_BITS-1:0] sample_q;
  logic signed [PW-1:0]          prod_d;
  logic signed [PW-1:0]          prod_q;

  assign prod_d = sample_i * tap_i;

  // window slot: hands its sample on to the next older cell each transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sample_q <= '0;
    end else if (shift_i) begin
      sample_q <= sample_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      prod_q <= prod_d;
    end
  end

  assign sample_o = sample_q;
  assign prod_o   = prod_q;

endmodule

`default_nettype wire

FILE: rtl/fircv_sum.sv
`default_nettype none

module fircv_sum #(
  parameter int N     = 8,
  parameter int IN_W  = 32,
  parameter int SUM_W = 35
) (
  input  wire  logic                        clk_i,
  input  wire  logic                        rst_ni,
  input  wire  fircv_pkg::fircv_tag_t       in_tag_i,
  output logic                              in_ready_o,
  input  wire  logic signed [IN_W-1:0]      term_i [N],
  output fircv_pkg::fircv_tag_t             out_tag_o,
  input  wire  logic                        out_ready_i,
  output logic signed [SUM_W-1:0]           sum_o
);
  import fircv_pkg::*;

  localparam int LV = (N > 1) ? $clog2(N) : 0;
  localparam int P  = 1 << LV;

  logic signed [SUM_W-1:0] leaf [P];

  for (genvar i = 0; i < P; i++) begin : g_leaf
    if (i < N) begin : g_used
      assign leaf[i] = SUM_W'(term_i[i]);
    end else begin : g_pad
      assign leaf[i] = '0;
    end
  end

  if (LV == 0) begin : g_single
    assign sum_o           = leaf[0];
    assign out_tag_o.valid = in_tag_i.valid;
    assign out_tag_o.eol   = in_tag_i.eol;
    assign in_ready_o      = out_ready_i;
  end else begin : g_tree
    // heap order: node 0 is the root, depth LV-1 is fed by the leaves
    logic signed [SUM_W-1:0] node_q [P-1];
    logic                    vld_q  [LV];
    logic                    eol_q  [LV];
    logic                    adv    [LV];

    // a level moves on when it is empty or the level after it moves on
    always_comb begin
      adv[0] = !vld_q[0] || out_ready_i;
      for (int d = 1; d < LV; d++) begin
        adv[d] = !vld_q[d] || adv[d-1];
      end
    end

    for (genvar d = 0; d < LV; d++) begin : g_lvl
      logic src_v;
      logic src_e;
      if (d == LV - 1) begin : g_first
        assign src_v = in_tag_i.valid;
        assign src_e = in_tag_i.eol;
      end else begin : g_next
        assign src_v = vld_q[d+1];
        assign src_e = eol_q[d+1];
      end

      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) begin
          vld_q[d] <= 1'b0;
        end else if (adv[d]) begin
          vld_q[d] <= src_v;
        end
      end

      always_ff @(posedge clk_i) begin
        if (adv[d]) begin
          eol_q[d] <= src_e;
        end
      end
    end

    for (genvar i = 0; i < P - 1; i++) begin : g_node
      localparam int D = $clog2(i + 2) - 1;
      localparam int L = 2 * i + 1;
      logic signed [SUM_W-1:0] a;
      logic signed [SUM_W-1:0] b;
      if (L >= P - 1) begin : g_from_leaf
        assign a = leaf[L-(P-1)];
        assign b = leaf[L+1-(P-1)];
      end else begin : g_from_node
        assign a = node_q[L];
        assign b = node_q[L+1];
      end

      always_ff @(posedge clk_i) begin
        if (adv[D]) begin
          node_q[i] <= a + b;
        end
      end
    end

    assign in_ready_o      = adv[LV-1];
    assign out_tag_o.valid = vld_q[0];
    assign out_tag_o.eol   = eol_q[0];
    assign sum_o           = node_q[0];
  end

endmodule

`default_nettype wire

FILE: rtl/fir_convolution_valid_1d_unit.sv
// path: after its input transfer a result passes the cell product registers, which
// load at the transfer, and then the register of each adder tree level in turn
// throughput: one sample per cycle while the result channel is ready; every stage holds its item while the next is full
// reset: kernel_size 1, tap 0 = 1.0, other taps zero, window and fill count cleared,
// pipeline empty
`default_nettype none

module fir_convolution_valid_1d_unit #(
  parameter int MAX_TAPS    = 8,
  parameter int SAMPLE_BITS = 16
) (
  input  wire  logic                                  clk_i,
  input  wire  logic                                  rst_ni,
  // sample channel
  input  wire  logic                                  in_valid_i,
  output logic                                        in_ready_o,
  input  wire  logic signed [SAMPLE_BITS-1:0]         sample_i,
  input  wire  logic                                  line_start_i,
  input  wire  logic                                  line_end_i,
  // result channel
  output logic                                        out_valid_o,
  input  wire  logic                                  out_ready_i,
  output logic signed [fircv_pkg::FILT_W-1:0]         filtered_o,
  output logic                                        end_of_line_o,
  // configuration
  input  wire  logic                                  psel,
  input  wire  logic                                  penable,
  input  wire  logic                                  pwrite,
  input  wire  logic [fircv_pkg::CFG_ADDR_W-1:0]      paddr,
  input  wire  logic [fircv_pkg::CFG_DATA_W-1:0]      pwdata,
  output logic [fircv_pkg::CFG_DATA_W-1:0]            prdata,
  output logic                                        pready
);
  import fircv_pkg::*;

  localparam int PW = SAMPLE_BITS + TAP_BITS;
  localparam int SW = PW + ((MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 0);
  localparam int KW = $clog2(MAX_TAPS + 1);
  localparam int IW = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
  localparam int CW = KW + 1;

  // configuration registers
  logic [KSIZE_W-1:0]    ksz_q;
  logic [CFG_DATA_W-1:0] taps_lo_q;
  logic [CFG_DATA_W-1:0] taps_hi_q;
  logic [REG_IDX_W-1:0]  reg_idx;
  logic                  cfg_wr;

  assign reg_idx = paddr[CFG_ADDR_W-1:3];
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ksz_q     <= KSIZE_RST;
      taps_lo_q <= TAPS_LO_RST;
      taps_hi_q <= TAPS_HI_RST;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_KSIZE:   ksz_q     <= pwdata[KSIZE_W-1:0];
        REG_TAPS_LO: taps_lo_q <= pwdata;
        REG_TAPS_HI: taps_hi_q <= pwdata;
        default:     ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_KSIZE:   prdata = CFG_DATA_W'(ksz_q);
      REG_TAPS_LO: prdata = taps_lo_q;
      REG_TAPS_HI: prdata = taps_hi_q;
      default:     prdata = '0;
    endcase
  end

  // taps in use, zero treated as one and large sizes clipped
  logic [KW-1:0] k_eff;

  always_comb begin
    if (ksz_q == '0) begin
      k_eff = KW'(1);
    end else if (ksz_q > KSIZE_W'(MAX_TAPS)) begin
      k_eff = KW'(MAX_TAPS);
    end else begin
      k_eff = ksz_q[KW-1:0];
    end
  end

  logic signed [TAP_BITS-1:0] tap_w   [MAX_TAPS];
  logic signed [TAP_BITS-1:0] tap_sel [MAX_TAPS];

  for (genvar j = 0; j < MAX_TAPS; j++) begin : g_tap
    if (j < TAPS_PER_WORD) begin : g_lo
      assign tap_w[j] = taps_lo_q[TAP_BITS*j +: TAP_BITS];
    end else begin : g_hi
      assign tap_w[j] = taps_hi_q[TAP_BITS*(j-TAPS_PER_WORD) +: TAP_BITS];
    end
  end

  // cell of age a multiplies by tap k-1-a, or by zero beyond the kernel
  always_comb begin
    logic [KW-1:0] idx;
    for (int a = 0; a < MAX_TAPS; a++) begin
      idx = k_eff - KW'(1) - KW'(a);
      if (KW'(a) < k_eff) begin
        tap_sel[a] = tap_w[idx[IW-1:0]];
      end else begin
        tap_sel[a] = '0;
      end
    end
  end

  // fill count and product stage control
  logic [IW-1:0] fill_q;
  logic [IW-1:0] fill_d;
  logic [IW-1:0] fill_eff;
  logic          produce;
  logic          accept;
  logic          v1_q;
  logic          v1_d;
  logic          eol1_q;
  logic          tree_ready;

  assign accept   = in_valid_i && in_ready_o;
  assign fill_eff = line_start_i ? '0 : fill_q;
  assign produce  = (CW'(fill_eff) + CW'(1)) >= CW'(k_eff);
  assign fill_d   = (CW'(fill_eff) < CW'(MAX_TAPS - 1)) ? fill_eff + IW'(1) : fill_eff;

  assign in_ready_o = !v1_q || tree_ready;

  always_comb begin
    if (accept) begin
      v1_d = produce;
    end else if (tree_ready) begin
      v1_d = 1'b0;
    end else begin
      v1_d = v1_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
      v1_q   <= 1'b0;
    end else begin
      v1_q <= v1_d;
      if (accept) begin
        fill_q <= fill_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      eol1_q <= line_end_i;
    end
  end

  // row of window cells: cell 0 sees the incoming sample
  logic signed [SAMPLE_BITS-1:0] chain [MAX_TAPS+1];
  logic signed [PW-1:0]          prod  [MAX_TAPS];

  assign chain[0] = sample_i;

  for (genvar a = 0; a < MAX_TAPS; a++) begin : g_cell
    fircv_cell #(
      .SAMPLE_BITS (SAMPLE_BITS)
    ) u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .shift_i  (accept),
      .sample_i (chain[a]),
      .tap_i    (tap_sel[a]),
      .sample_o (chain[a+1]),
      .prod_o   (prod[a])
    );
  end

  fircv_tag_t              tag1;
  fircv_tag_t              tag_out;
  logic signed [SW-1:0]    sum;

  assign tag1.valid = v1_q;
  assign tag1.eol   = eol1_q;

  fircv_sum #(
    .N     (MAX_TAPS),
    .IN_W  (PW),
    .SUM_W (SW)
  ) u_sum (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_tag_i    (tag1),
    .in_ready_o  (tree_ready),
    .term_i      (prod),
    .out_tag_o   (tag_out),
    .out_ready_i (out_ready_i),
    .sum_o       (sum)
  );

  assign out_valid_o   = tag_out.valid;
  assign end_of_line_o = tag_out.eol;
  assign filtered_o    = FILT_W'(sum);

  // a line start with a multi-tap kernel never gives a result for its first sample
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && line_start_i && (k_eff > KW'(1))) |=> !v1_q)
    else $error("result made for first sample of a line");

  // a single-tap kernel gives a result for every transfer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (k_eff == KW'(1))) |=> v1_q)
    else $error("single-tap kernel dropped a result");

  // input is only held off while the product stage is occupied
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> v1_q)
    else $error("input stalled with empty product stage");

  // the fill count saturates one below the tap count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    CW'(fill_q) <= CW'(MAX_TAPS - 1))
    else $error("fill count out of range");

endmodule

`default_nettype wire
